// ===== sv/cgr_pkg.sv =====
// Shared types, constants and the quarter-sine gain table for the crossfade gate router.
// No dependencies; every other file of the block imports this package.
package cgr_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SEL_BITS    = 4;
  localparam int CNT_BITS    = 17;
  localparam int PHASE_BITS  = 10;
  localparam int PHASE_STEPS = 1 << PHASE_BITS;
  localparam int GAIN_BITS   = 16;
  localparam int FADE_MAX    = 65536;
  localparam int ROUND_BIT   = 15;

  localparam logic [GAIN_BITS-1:0] FULL_GAIN = 16'h7FFF;

  // Register map, decoded on paddr[2].
  localparam logic REG_OUTPUTS = 1'b0;
  localparam logic REG_FADE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_LOOK,
    ST_MUL,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef logic [PHASE_STEPS-1:0][GAIN_BITS-1:0] sine_tab_t;

  // Floor of num / den for non-negative operands below 2^35, by shift and subtract.
  // Used only while the gain table is built.
  function automatic longint div_floor(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 34; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // Entry i is sin(pi/2 * i/1024) in Q1.15, built with a Q2.30 Taylor series,
  // rounded half up and capped at full scale.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint    a;
    longint    a2;
    longint    term;
    longint    sum;
    longint    v;
    for (int i = 0; i < PHASE_STEPS; i++) begin
      a    = (64'sd1686629713 * longint'(i)) >>> PHASE_BITS;
      a2   = (a * a) >>> 30;
      term = a;
      sum  = a;
      for (int k = 1; k <= 8; k++) begin
        term = (term * a2) >>> 30;
        term = div_floor(term, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      tab[i] = v[GAIN_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== sv/cgr_counter_mem.sv =====
// Fade counter store: one counter per channel, one read and one write port.
// Depends on cgr_pkg; valid bits make unwritten counters read as zero after reset.
module cgr_counter_mem #(
  parameter int CHANNELS = cgr_pkg::CHANNELS_DEF,
  parameter int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [IDX_BITS-1:0]          raddr,
  output logic [cgr_pkg::CNT_BITS-1:0] rdata,
  input  logic                         we,
  input  logic [IDX_BITS-1:0]          waddr,
  input  logic [cgr_pkg::CNT_BITS-1:0] wdata
);
  import cgr_pkg::*;

  logic [CNT_BITS-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  logic [CNT_BITS-1:0] rd_raw;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw   <= mem[raddr];
    rd_valid <= valid[raddr];
  end

  assign rdata = rd_valid ? rd_raw : '0;

endmodule

// ===== sv/cgr_phase_div.sv =====
// Serial restoring divider for the fade phase, floor(count * 1024 / length).
// Depends on cgr_pkg; the dividend must be below the divisor, one quotient bit per cycle.
module cgr_phase_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cgr_pkg::CNT_BITS-1:0]   dividend,
  input  logic [cgr_pkg::CNT_BITS-1:0]   divisor,
  output logic                           done,
  output logic [cgr_pkg::PHASE_BITS-1:0] quotient
);
  import cgr_pkg::*;

  localparam int STEP_BITS = $clog2(PHASE_BITS + 1);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [CNT_BITS-1:0]  rem;
  logic [CNT_BITS-1:0]  den;
  logic [CNT_BITS:0]    shifted;
  logic [CNT_BITS:0]    diff;
  logic                 fits;
  logic [CNT_BITS-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, 1'b0};
    diff     = shifted - {1'b0, den};
    fits     = shifted >= {1'b0, den};
    rem_next = fits ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_BITS'(1);
      if (step == STEP_BITS'(PHASE_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[PHASE_BITS-2:0], fits};
    end
  end

endmodule

// ===== sv/cgr_sine_rom.sv =====
// Quarter-sine gain ROM with a registered read port.
// Depends on cgr_pkg for the table contents.
module cgr_sine_rom (
  input  logic                           clk,
  input  logic [cgr_pkg::PHASE_BITS-1:0] addr,
  output logic [cgr_pkg::GAIN_BITS-1:0]  data
);
  import cgr_pkg::*;

  always_ff @(posedge clk) begin
    data <= SINE_TAB[addr];
  end

endmodule

// ===== sv/crossfade_gate_router.sv =====
// Top level of the equal-power crossfade gate router: sequencer, registers and output stage.
// Depends on cgr_pkg, cgr_counter_mem, cgr_phase_div and cgr_sine_rom.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   s_tdata: sample; s_tuser: select
//   m_*       out        m_tvalid/m_tready   m_tdata: out_sample; m_tuser: channel, closed;
//                                            m_tlast: last
//   APB       in/out     psel/penable        paddr, pwdata, prdata (two registers)
//
// Each request is worked one served channel at a time through one shared serial divider,
// one gain ROM and one multiplier. A channel whose fade is in progress passes through the
// read, update, divide, look-up, multiply, round and output steps; one at full gain skips
// the divide and look-up steps, and a low m_tready holds it in the output step.
// Reset is synchronous on rst: it returns the sequencer to idle, sets both registers to 1
// and marks all fade counters as zero.
// s_tready is high only while idle; a stalled result holds the sequencer in place.
module crossfade_gate_router #(
  parameter int CHANNELS    = cgr_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = cgr_pkg::SAMPLE_BITS_DEF,
  parameter int DATA_BITS   = ((SAMPLE_BITS + 7) >> 3) << 3
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_BITS-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [3:0]           s_tuser,   // [3:0] select
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_BITS-1:0] m_tdata,   // [SAMPLE_BITS-1:0] out_sample, rest zero
  output logic [3:0]           m_tuser,   // [2:0] channel, [3] closed
  output logic                 m_tlast,
  // Register port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cgr_pkg::*;

  localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W     = $clog2(CHANNELS + 1);
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int RES_BITS  = PROD_BITS - ROUND_BIT;

  localparam logic signed [RES_BITS-1:0] MAX_OUT = RES_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_BITS-1:0] MIN_OUT = RES_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // Configuration registers.
  logic [SEL_BITS-1:0] outputs_in_use;
  logic [CNT_BITS-1:0] fade_length;
  logic                cfg_write;

  // Per-request registers.
  state_t                        state;
  state_t                        state_next;
  logic [IDX_BITS-1:0]           chan;
  logic [CNT_W-1:0]              served;
  logic [CNT_W-1:0]              sel;
  logic [CNT_BITS-1:0]           len;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          closed;
  logic                          full;
  logic signed [PROD_BITS-1:0]   prod;

  // Values worked out at the input handshake.
  logic [CNT_W-1:0]    served_next;
  logic [CNT_W-1:0]    sel_next;
  logic [CNT_BITS-1:0] len_next;

  // Counter update for the channel in hand.
  logic [CNT_BITS-1:0] cnt_rdata;
  logic [CNT_BITS-1:0] cnt_wdata;
  logic                cnt_we;
  logic                active;
  logic                closed_next;
  logic                full_next;
  logic [CNT_W-1:0]    chan_num;
  logic                chan_last;

  // Shared units.
  logic                  div_start;
  logic                  div_done;
  logic [PHASE_BITS-1:0] phase;
  logic [GAIN_BITS-1:0]  rom_data;
  logic [GAIN_BITS-1:0]  gain;

  // Rounding and saturation.
  logic signed [PROD_BITS-1:0]   prod_rnd;
  logic signed [RES_BITS-1:0]    res;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  logic s_accept;
  logic m_accept;

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // ---------------------------------------------------------------------------
  // Register port. The port never waits; writes land on the access cycle and the
  // low address bits are ignored.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outputs_in_use <= SEL_BITS'(1);
      fade_length    <= CNT_BITS'(1);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_OUTPUTS: outputs_in_use <= pwdata[SEL_BITS-1:0];
        REG_FADE:    fade_length    <= pwdata[CNT_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OUTPUTS: prdata = {{(32 - SEL_BITS){1'b0}}, outputs_in_use};
      REG_FADE:    prdata = {{(32 - CNT_BITS){1'b0}}, fade_length};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request setup. The served count is clamped to 1..CHANNELS, the fade length
  // to 1..65536, and the selection to the served count; the new selection
  // already governs this request's counters.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (outputs_in_use == '0) begin
      served_next = CNT_W'(1);
    end else if (int'(outputs_in_use) > CHANNELS) begin
      served_next = CNT_W'(CHANNELS);
    end else begin
      served_next = CNT_W'(outputs_in_use);
    end

    if (int'(s_tuser) > int'(served_next)) begin
      sel_next = served_next;
    end else begin
      sel_next = CNT_W'(s_tuser);
    end

    if (fade_length == '0) begin
      len_next = CNT_BITS'(1);
    end else if (int'(fade_length) > FADE_MAX) begin
      len_next = CNT_BITS'(FADE_MAX);
    end else begin
      len_next = fade_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Fade counter step. The selected channel climbs toward the fade length and
  // holds at or above it; every other served channel falls toward zero, and the
  // step that lands on zero marks the channel as closed.
  // ---------------------------------------------------------------------------
  always_comb begin
    chan_num    = CNT_W'(chan) + CNT_W'(1);
    chan_last   = chan_num == served;
    active      = sel == chan_num;
    cnt_wdata   = cnt_rdata;
    closed_next = 1'b0;
    if (active && (cnt_rdata < len)) begin
      cnt_wdata = cnt_rdata + CNT_BITS'(1);
    end else if (!active && (cnt_rdata != '0)) begin
      cnt_wdata   = cnt_rdata - CNT_BITS'(1);
      closed_next = cnt_rdata == CNT_BITS'(1);
    end
    // At or past the fade length the phase reaches a full quarter turn.
    full_next = cnt_wdata >= len;
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cnt_we     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cnt_we = 1'b1;
        if (full_next) begin
          state_next = ST_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = chan_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Request and per-channel working registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sample <= $signed(s_tdata[SAMPLE_BITS-1:0]);
      served <= served_next;
      sel    <= sel_next;
      len    <= len_next;
      chan   <= '0;
    end else if ((state == ST_OUT) && m_tready && !chan_last) begin
      chan <= chan + IDX_BITS'(1);
    end
    if (state == ST_UPDATE) begin
      closed <= closed_next;
      full   <= full_next;
    end
    if (state == ST_MUL) begin
      prod <= sample * $signed({1'b0, gain});
    end
  end

  // ---------------------------------------------------------------------------
  // Shared units: counter store, phase divider, gain ROM.
  // ---------------------------------------------------------------------------
  cgr_counter_mem #(
    .CHANNELS (CHANNELS),
    .IDX_BITS (IDX_BITS)
  ) u_counters (
    .clk   (clk),
    .rst   (rst),
    .raddr (chan),
    .rdata (cnt_rdata),
    .we    (cnt_we),
    .waddr (chan),
    .wdata (cnt_wdata)
  );

  cgr_phase_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cnt_wdata),
    .divisor  (len),
    .done     (div_done),
    .quotient (phase)
  );

  cgr_sine_rom u_rom (
    .clk  (clk),
    .addr (phase),
    .data (rom_data)
  );

  assign gain = full ? FULL_GAIN : rom_data;

  // ---------------------------------------------------------------------------
  // Round half up, shift back to Q1.15 and saturate to the sample range.
  // ---------------------------------------------------------------------------
  always_comb begin
    prod_rnd = prod + PROD_BITS'(1 << (ROUND_BIT - 1));
    res      = prod_rnd[PROD_BITS-1:ROUND_BIT];
    if (res > MAX_OUT) begin
      res_sat = MAX_OUT[SAMPLE_BITS-1:0];
    end else if (res < MIN_OUT) begin
      res_sat = MIN_OUT[SAMPLE_BITS-1:0];
    end else begin
      res_sat = res[SAMPLE_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_ROUND) begin
      m_tvalid <= 1'b1;
    end else if (m_accept) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      m_tdata <= DATA_BITS'($unsigned(res_sat));
      m_tuser <= {closed, 3'(chan)};
      m_tlast <= chan_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while a result is still pending");

  a_closed_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) && closed_next |-> (cnt_wdata == '0) && !active)
    else $error("closed flag raised on a counter that is not zero");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    m_accept && m_tlast |=> s_tready)
    else $error("sequencer did not return to idle after the last result");

  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chan_num <= served))
    else $error("result for a channel beyond the served count");

  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_ROUND))
    else $error("result raised outside the rounding step");

endmodule
